>>> src/polar_tunnel_pixel_shader_defines.svh
// Assertion helpers for the tunnel shader. They compile to nothing in synthesis.
`ifndef POLAR_TUNNEL_PIXEL_SHADER_DEFINES_SVH
`define POLAR_TUNNEL_PIXEL_SHADER_DEFINES_SVH
`ifndef SYNTHESIS
`define PTS_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pts: same-cycle check failed");
`define PTS_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pts: next-cycle check failed");
`else
`define PTS_ASSERT_IMP(name, clk, rstn, ante, cons)
`define PTS_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif
`endif

>>> src/pts_pkg.sv
`timescale 1ns / 1ps
package pts_pkg;

    localparam int IMAGE_WIDTH      = 640;
    localparam int IMAGE_HEIGHT     = 480;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;

    // Datapath widths: CORDIC x/y, angle, radius, divider numerator and divisor.
    localparam int CW = 21;
    localparam int ZW = 34;
    localparam int RW = 17;
    localparam int NW = 25;
    localparam int DW = 18;

    localparam logic [9:0] COL_MAX = 10'(IMAGE_WIDTH - 1);
    localparam logic [9:0] ROW_MAX = 10'(IMAGE_HEIGHT - 1);

    // ceil(2^38 / size): col * RECIP >> 21 equals floor(col * 2^17 / size) exactly.
    localparam logic [37:0] RECIP_X = 38'(((64'sd1 <<< 38) + IMAGE_WIDTH - 1) / IMAGE_WIDTH);
    localparam logic [37:0] RECIP_Y =
        38'(((64'sd1 <<< 38) + IMAGE_HEIGHT - 1) / IMAGE_HEIGHT);

    localparam logic signed [ZW-1:0] PI_Q30       = 34'sd3373259426;
    localparam logic [29:0]          INV_GAIN_Q30 = 30'd652032874;
    localparam logic [23:0]          V_SCALE_Q16  = 24'd15958479;
    localparam logic [NW-1:0]        U_NUM_BASE   = 25'd33423360;

    localparam logic signed [ZW-1:0] ATAN_Q30 [ATAN_LEN] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [15:0]          tsc;
    } cordic_t;

    typedef struct packed {
        logic [DW-1:0] rem;
        logic [NW-1:0] num;
        logic [DW-1:0] den;
        logic [7:0]    quo;
        logic [RW-1:0] r;
        logic [7:0]    v;
        logic [15:0]   tsc;
    } div_t;

endpackage

>>> src/polar_tunnel_pixel_shader.sv
`timescale 1ns / 1ps
`include "polar_tunnel_pixel_shader_defines.svh"
// Tunnel shader: takes one pixel position and a frame time per word and returns one shaded
// grey pixel per word, one word per clock when both sides keep up. The depth is set by one
// stage per CORDIC iteration and one per quotient bit of the 25-bit 1/r divider. The pipeline
// freezes as a whole while a finished result waits; the first stage still fills if empty.
module polar_tunnel_pixel_shader
    import pts_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [9:0] column, [19:10] row, [37:20] frame_time, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [23:0] pixel_word, [31:24] grey_level
);

    logic adv;
    logic en1;

    // Stage 1: position scaling products.
    logic [9:0]  col_c;
    logic [9:0]  row_c;
    logic        s1_v_reg;
    logic [47:0] prod_x_reg;
    logic [47:0] prod_y_reg;
    logic [15:0] tsc1_reg;

    // CORDIC stages: entry 0 is the pre-rotation, entry k+1 follows iteration k.
    cordic_t              cord_reg  [CORDIC_STEPS+1];
    cordic_t              cord_next [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] cv_reg;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;

    // Product stage.
    logic                 p_v_reg;
    logic signed [51:0]   pr_r_reg;
    logic signed [58:0]   pr_v_reg;
    logic [15:0]          p_tsc_reg;

    // Divider stages.
    div_t          div_reg  [NW+1];
    div_t          div_next [NW+1];
    logic [NW:0]   dv_reg;
    logic [RW-1:0] r_q;
    logic signed [58:0] vsum;

    // Finishing stages.
    logic          f1_v_reg;
    logic [7:0]    f1_u_reg;
    logic [7:0]    f1_v8_reg;
    logic [15:0]   f1_tsc_reg;
    logic [33:0]   f1_r2_reg;
    logic          f2_v_reg;
    logic [7:0]    f2_w_reg;
    logic [7:0]    f2_g_reg;
    logic [32:0]   r2c;
    logic [40:0]   wsum;
    logic [15:0]   idx;
    logic [7:0]    txor;
    logic [10:0]   gsum;
    logic [15:0]   gw;
    logic          out_v_reg;
    logic [7:0]    grey_reg;

    assign adv      = !out_v_reg || m_tready;
    assign en1      = adv || !s1_v_reg;
    assign s_tready = en1;

    always_comb begin
        col_c = (s_tdata[9:0] > COL_MAX) ? COL_MAX : s_tdata[9:0];
        row_c = (s_tdata[19:10] > ROW_MAX) ? ROW_MAX : s_tdata[19:10];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (en1) begin
            s1_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            prod_x_reg <= 48'(col_c) * 48'(RECIP_X);
            prod_y_reg <= 48'(row_c) * 48'(RECIP_Y);
            tsc1_reg   <= s_tdata[37:22];
        end
    end

    // Map x to [-1,1) and y to (-1,1] in Q16 and fold the left half plane onto the right one.
    always_comb begin
        x0 = $signed({3'b000, prod_x_reg[38:21]}) - CW'(65536);
        y0 = CW'(65536) - $signed({3'b000, prod_y_reg[38:21]});
        cord_next[0].tsc = tsc1_reg;
        if (x0 < 0) begin
            cord_next[0].x = -x0;
            cord_next[0].y = -y0;
            cord_next[0].z = (y0 >= 0) ? PI_Q30 : -PI_Q30;
        end else begin
            cord_next[0].x = x0;
            cord_next[0].y = y0;
            cord_next[0].z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg[0] <= 1'b0;
        end else if (adv) begin
            cv_reg[0] <= s1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cord_reg[0] <= cord_next[0];
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        always_comb begin
            cord_next[k+1].tsc = cord_reg[k].tsc;
            if (cord_reg[k].y >= 0) begin
                cord_next[k+1].x = cord_reg[k].x + (cord_reg[k].y >>> k);
                cord_next[k+1].y = cord_reg[k].y - (cord_reg[k].x >>> k);
                cord_next[k+1].z = cord_reg[k].z + ATAN_Q30[k];
            end else begin
                cord_next[k+1].x = cord_reg[k].x - (cord_reg[k].y >>> k);
                cord_next[k+1].y = cord_reg[k].y + (cord_reg[k].x >>> k);
                cord_next[k+1].z = cord_reg[k].z - ATAN_Q30[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[k+1] <= 1'b0;
            end else if (adv) begin
                cv_reg[k+1] <= cv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                cord_reg[k+1] <= cord_next[k+1];
            end
        end
    end

    // Gain correction for the radius and 765/pi scaling for the angle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_v_reg <= 1'b0;
        end else if (adv) begin
            p_v_reg <= cv_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pr_r_reg  <= 52'(cord_reg[CORDIC_STEPS].x) * $signed({1'b0, INV_GAIN_Q30});
            pr_v_reg  <= 59'(cord_reg[CORDIC_STEPS].z) * $signed({1'b0, V_SCALE_Q16});
            p_tsc_reg <= cord_reg[CORDIC_STEPS].tsc;
        end
    end

    always_comb begin
        r_q  = (pr_r_reg < 0) ? '0 : pr_r_reg[46:30];
        vsum = pr_v_reg + (59'sd1 <<< 45);
        div_next[0].rem = '0;
        div_next[0].num = U_NUM_BASE + NW'(r_q);
        div_next[0].den = {r_q, 1'b0};
        div_next[0].quo = '0;
        div_next[0].r   = r_q;
        div_next[0].v   = vsum[53:46];
        div_next[0].tsc = p_tsc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_reg[0] <= p_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            div_reg[0] <= div_next[0];
        end
    end

    // Restoring division, one quotient bit per stage; only the low byte is kept.
    for (genvar i = 0; i < NW; i++) begin : g_div
        logic [DW:0] trial;
        logic        ge;

        always_comb begin
            trial = {div_reg[i].rem, div_reg[i].num[NW-1]};
            ge    = (trial >= {1'b0, div_reg[i].den});
            div_next[i+1]     = div_reg[i];
            div_next[i+1].rem = ge ? DW'(trial - {1'b0, div_reg[i].den}) : DW'(trial);
            div_next[i+1].num = {div_reg[i].num[NW-2:0], 1'b0};
            div_next[i+1].quo = {div_reg[i].quo[6:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[i+1] <= 1'b0;
            end else if (adv) begin
                dv_reg[i+1] <= dv_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                div_reg[i+1] <= div_next[i+1];
            end
        end
    end

    // The centre pixel has no defined 1/r, so u is forced to zero there.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            f1_v_reg  <= dv_reg[NW];
            f2_v_reg  <= f1_v_reg;
            out_v_reg <= f2_v_reg;
        end
    end

    always_comb begin
        r2c  = (f1_r2_reg > 34'h1_0000_0000) ? 33'h1_0000_0000 : f1_r2_reg[32:0];
        wsum = 41'({r2c, 8'h00}) - 41'(r2c) + (41'd1 << 31);
        idx  = {f1_v8_reg, f1_u_reg} + f1_tsc_reg;
        txor = idx[7:0] ^ idx[15:8];
        gsum = ((idx[6] ^ idx[14]) ? 11'd1275 : 11'd0) + 11'({txor, 1'b0}) + 11'(txor);
        gw   = 16'(f2_g_reg) * 16'(f2_w_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_u_reg   <= (div_reg[NW].r == '0) ? 8'h00 : div_reg[NW].quo;
            f1_v8_reg  <= div_reg[NW].v;
            f1_tsc_reg <= div_reg[NW].tsc;
            f1_r2_reg  <= 34'(div_reg[NW].r) * 34'(div_reg[NW].r);
            f2_w_reg   <= wsum[39:32];
            f2_g_reg   <= gsum[10:3];
            grey_reg   <= gw[15:8];
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {grey_reg, grey_reg, grey_reg, grey_reg};

    `PTS_ASSERT_NXT(a_accept_fills_first, aclk, aresetn, s_tvalid && s_tready, s1_v_reg)
    `PTS_ASSERT_NXT(a_stall_freezes_cordic, aclk, aresetn, m_tvalid && !m_tready, $stable(cv_reg))
    `PTS_ASSERT_NXT(a_dark_shade_black, aclk, aresetn, f2_v_reg && adv && f2_w_reg == 8'h00,
        m_tvalid && grey_reg == 8'h00)

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import pts_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // [9:0] column, [19:10] row, [37:20] frame_time, zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [23:0] pixel_word, [31:24] grey_level

    localparam int LATENCY = CORDIC_STEPS_DEF + 32;

    int errors = 0;

    typedef struct {
        logic [23:0] pixel_word;
        logic [7:0]  grey_level;
    } shade_t;

    polar_tunnel_pixel_shader u_top (.*);

    always #4 aclk = ~aclk;

    function automatic longint floor_shift(longint v, int k);
        if (v >= 0)
            return v >>> k;
        return -((-(v + 1)) >>> k) - 1;
    endfunction

    // Fixed-point tunnel mapping: polar conversion, texture lookup and shading.
    function automatic shade_t shade_pixel(logic [9:0] column, logic [9:0] row,
                                           logic [17:0] frame_time);
        longint col, rw, x, y, z, xs, ys, r, r2, iu, iv, iw, idx, ti, tj, chk, g, grey;
        shade_t res;
        col = column;
        rw = row;
        if (col > IMAGE_WIDTH - 1) col = IMAGE_WIDTH - 1;
        if (rw > IMAGE_HEIGHT - 1) rw = IMAGE_HEIGHT - 1;
        x = (2 * col * 65536) / IMAGE_WIDTH - 65536;
        y = 65536 - (2 * rw * 65536) / IMAGE_HEIGHT;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
            x = -x;
            y = -y;
        end
        for (int k = 0; k < CORDIC_STEPS_DEF; k++) begin
            xs = floor_shift(x, k);
            ys = floor_shift(y, k);
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_Q30[k]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_Q30[k]);
            end
        end
        r = floor_shift(x * longint'(INV_GAIN_Q30), 30);
        if (r < 0) r = 0;
        // The centre pixel has no defined distance, so u is forced to zero there.
        iu = (r == 0) ? 0 : ((2 * 255 * 65536 + r) / (2 * r)) & 255;
        iv = floor_shift(z * longint'(V_SCALE_Q16) + (longint'(1) <<< 45), 46) & 255;
        r2 = r * r;
        if (r2 > (longint'(1) <<< 32)) r2 = longint'(1) <<< 32;
        iw = (r2 * 255 + (longint'(1) <<< 31)) >>> 32;
        if (iw > 255) iw = 255;
        idx = (((iv << 8) | iu) + (frame_time >> 2)) & 16'hffff;
        ti = idx & 255;
        tj = idx >> 8;
        chk = (((ti >> 6) ^ (tj >> 6)) & 1) * 255;
        g = (chk * 5 + 3 * (ti ^ tj)) >> 3;
        grey = ((g * iw) >> 8) & 255;
        res.grey_level = grey[7:0];
        res.pixel_word = {3{grey[7:0]}};
        return res;
    endfunction

    class shade_scoreboard;
        shade_t pending[$];

        function void note_pixel(logic [39:0] word);
            pending.push_back(shade_pixel(word[9:0], word[19:10], word[37:20]));
        endfunction

        function void check_pixel(logic [31:0] word);
            shade_t want;
            if (pending.size() == 0) begin
                $error("unexpected result word %h", word);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (word[23:0] !== want.pixel_word) begin
                $error("pixel_word: expected %h, got %h", want.pixel_word, word[23:0]);
                errors++;
            end
            if (word[31:24] !== want.grey_level) begin
                $error("grey_level: expected %h, got %h", want.grey_level, word[31:24]);
                errors++;
            end
        endfunction
    endclass

    shade_scoreboard board = new();
    bit calm = 1'b0;    // no idling on either side while set

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_pixel(s_tdata);
            if (m_tvalid && m_tready) board.check_pixel(m_tdata);
            m_tready <= calm || ($urandom_range(0, 99) >= 16);
        end
    end

    task automatic send_pixel(logic [9:0] column, logic [9:0] row, logic [17:0] frame_time);
        while (!calm && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, frame_time, row, column};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin
        logic [9:0] c, r;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Corners, centre pixel, out-of-range clamping and field extremes.
        send_pixel(0, 0, 0);
        send_pixel(639, 0, 18'h3ffff);
        send_pixel(0, 479, 4);
        send_pixel(639, 479, 3);
        send_pixel(320, 240, 0);
        send_pixel(320, 240, 18'h3ffff);
        send_pixel(10'h3ff, 10'h3ff, 18'h2aaaa);
        send_pixel(640, 480, 18'h15555);
        send_pixel(10'h3ff, 0, 1);
        send_pixel(0, 10'h3ff, 18'h20000);
        send_pixel(319, 240, 100);
        send_pixel(321, 239, 200);
        send_pixel(320, 0, 7);
        send_pixel(0, 240, 8);
        send_pixel(10'h155, 10'h2aa, 18'h0ffff);
        send_pixel(10'h2aa, 10'h155, 18'h30000);
        for (int i = 0; i < 1250; i++) begin
            calm = (i >= 500 && i < 650);
            case ($urandom_range(0, 9))
                0: begin
                    c = 10'($urandom);
                    r = 10'($urandom);
                end
                1: begin
                    c = 10'(320 + $urandom_range(0, 4) - 2);
                    r = 10'(240 + $urandom_range(0, 4) - 2);
                end
                default: begin
                    c = 10'($urandom_range(0, 639));
                    r = 10'($urandom_range(0, 479));
                end
            endcase
            send_pixel(c, r, 18'($urandom));
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
